// ----- hw/rtl/bls_pkg.sv -----
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and codes for the byte stack: command and error codes,
// the descriptor that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;
    localparam int ERR_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_N = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_N  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STATUS = 3'd5;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_COUNT = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd3;

    // descriptor kinds
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_PUSH  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] wr_byte;
        logic [CNT_W-1:0]  addr;
        logic [CNT_W-1:0]  run_len;
        logic [ERR_W-1:0]  err;
        logic [CNT_W-1:0]  occ;
    } desc_t;

endpackage

// ----- hw/rtl/byte_lifo_stack_top.sv -----
// ----------------------------------------------------------------------------
// byte_lifo_stack_top
// Byte stack of DEPTH entries with push, pop, peek, multi-byte runs and
// status query commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel in_valid/in_stall carries command, push_byte and count.
//   Result channel out_valid/out_stall carries one transaction per result;
//   multi-byte runs come deepest byte first, the top byte marked by last.
//   The front end checks each command and moves the stack pointer at once;
//   a four-entry queue holds the work for the back end, which owns the
//   stack memory. in_stall rises only when that queue is full.
//   A result without data passes the queue entry, the back-end descriptor
//   register and the result register; a read result also passes the
//   registered memory read port. The back-end sequencer takes the next
//   descriptor only after the last result of the current one is loaded,
//   and reads memory through its registered read port before each result.
//   When out_stall is high the result register holds; the queue keeps
//   taking commands until it fills.
//   Reset empties the stack and the queue; memory contents are not cleared.
// ----------------------------------------------------------------------------
module byte_lifo_stack_top #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [bls_pkg::CMD_W-1:0]  command,
    input  logic [bls_pkg::BYTE_W-1:0] push_byte,
    input  logic [bls_pkg::CNT_W-1:0]  count,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [bls_pkg::BYTE_W-1:0] data_byte,
    output logic                       data_valid,
    output logic                       last,
    output logic [bls_pkg::ERR_W-1:0]  error,
    output logic [bls_pkg::CNT_W-1:0]  occupancy,
    output logic                       empty_res
);

    logic                      q_full;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_empty;
    bls_pkg::desc_t            q_in_desc;
    bls_pkg::desc_t            q_head;
    logic [bls_pkg::CNT_W-1:0] top_count;

    // command check and stack pointer
    bls_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .push_byte (push_byte),
        .count     (count),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (q_in_desc),
        .top_count (top_count)
    );

    // work queue
    bls_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_in_desc),
        .full      (q_full),
        .pop       (q_pop),
        .head_desc (q_head),
        .empty     (q_empty)
    );

    // memory access and result channel
    bls_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .data_valid (data_valid),
        .last       (last),
        .error      (error),
        .occupancy  (occupancy),
        .empty_res  (empty_res)
    );

    // stack pointer moves only on an accepted command
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall) |=> $stable(top_count))
        else $error("stack pointer moved without a command");

    // stack pointer never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        top_count <= bls_pkg::CNT_W'(DEPTH))
        else $error("stack pointer beyond depth");

    // an error result is a single result without data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error != bls_pkg::ERR_OK) |-> last && !data_valid)
        else $error("error result carries data or is not last");

    // reported occupancy and empty flag agree
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_res == (occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule

// ----- hw/rtl/bls_front.sv -----
// ----------------------------------------------------------------------------
// bls_front
// Accepts commands, checks them against the stack pointer, updates the
// pointer and hands a descriptor of the work to the command queue.
// ----------------------------------------------------------------------------
module bls_front #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [bls_pkg::CMD_W-1:0]  command,
    input  logic [bls_pkg::BYTE_W-1:0] push_byte,
    input  logic [bls_pkg::CNT_W-1:0]  count,
    input  logic                       q_full,
    output logic                       q_push,
    output bls_pkg::desc_t             q_desc,
    output logic [bls_pkg::CNT_W-1:0]  top_count
);

    logic [bls_pkg::CNT_W-1:0] top_reg;
    logic [bls_pkg::CNT_W-1:0] top_next;
    bls_pkg::desc_t            desc;

    // handshake toward the sender
    assign in_stall  = q_full;
    assign q_push    = in_valid && !q_full;
    assign q_desc    = desc;
    assign top_count = top_reg;

    // classify the command against the current occupancy
    always_comb
    begin
        desc.kind    = bls_pkg::KIND_PLAIN;
        desc.wr_byte = push_byte;
        desc.addr    = top_reg;
        desc.run_len = bls_pkg::CNT_W'(1);
        desc.err     = bls_pkg::ERR_OK;
        top_next     = top_reg;
        case (command)
            bls_pkg::CMD_PUSH:
            begin
                if (top_reg >= bls_pkg::CNT_W'(DEPTH))
                begin
                    desc.err = bls_pkg::ERR_FULL;
                end
                else
                begin
                    desc.kind = bls_pkg::KIND_PUSH;
                    top_next  = top_reg + bls_pkg::CNT_W'(1);
                end
            end
            bls_pkg::CMD_POP, bls_pkg::CMD_PEEK:
            begin
                if (top_reg == '0)
                begin
                    desc.err = bls_pkg::ERR_EMPTY;
                end
                else
                begin
                    desc.kind = bls_pkg::KIND_READ;
                    desc.addr = top_reg - bls_pkg::CNT_W'(1);
                    if (command == bls_pkg::CMD_POP)
                    begin
                        top_next = top_reg - bls_pkg::CNT_W'(1);
                    end
                end
            end
            bls_pkg::CMD_PEEK_N, bls_pkg::CMD_POP_N:
            begin
                if (count > top_reg)
                begin
                    desc.err = bls_pkg::ERR_COUNT;
                end
                else if (count != '0)
                begin
                    desc.kind    = bls_pkg::KIND_READ;
                    desc.addr    = top_reg - count;
                    desc.run_len = count;
                    if (command == bls_pkg::CMD_POP_N)
                    begin
                        top_next = top_reg - count;
                    end
                end
            end
            default:
            begin
                desc.kind = bls_pkg::KIND_PLAIN;
            end
        endcase
        desc.occ = top_next;
    end

    // stack pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else if (q_push)
        begin
            top_reg <= top_next;
        end
    end

endmodule

// ----- hw/rtl/bls_queue.sv -----
// ----------------------------------------------------------------------------
// bls_queue
// Short descriptor queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bls_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bls_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output bls_pkg::desc_t head_desc,
    output logic           empty
);

    bls_pkg::desc_t              entry_reg [bls_pkg::QDEPTH];
    logic [bls_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [bls_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [bls_pkg::QPTR_W:0]    fill_reg;
    logic                        do_push;
    logic                        do_pop;

    assign full      = fill_reg == (bls_pkg::QPTR_W + 1)'(bls_pkg::QDEPTH);
    assign empty     = fill_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_desc = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bls_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bls_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + (bls_pkg::QPTR_W + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - (bls_pkg::QPTR_W + 1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- hw/rtl/bls_back.sv -----
// ----------------------------------------------------------------------------
// bls_back
// Carries out descriptors: writes pushed bytes into the stack memory,
// reads runs of bytes back and drives the registered result channel.
// ----------------------------------------------------------------------------
module bls_back #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  bls_pkg::desc_t             q_head,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [bls_pkg::BYTE_W-1:0] data_byte,
    output logic                       data_valid,
    output logic                       last,
    output logic [bls_pkg::ERR_W-1:0]  error,
    output logic [bls_pkg::CNT_W-1:0]  occupancy,
    output logic                       empty_res
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [bls_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [bls_pkg::BYTE_W-1:0] rd_data_reg;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [bls_pkg::CNT_W-1:0]  idx_reg;
    logic [bls_pkg::CNT_W-1:0]  idx_next;
    bls_pkg::desc_t             cur_reg;
    bls_pkg::desc_t             cur_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [bls_pkg::BYTE_W-1:0] data_byte_reg;
    logic                       data_valid_reg;
    logic                       last_reg;
    logic [bls_pkg::ERR_W-1:0]  error_reg;
    logic [bls_pkg::CNT_W-1:0]  occupancy_reg;
    logic                       empty_res_reg;

    logic                       slot_free;
    logic                       load;
    logic                       mem_we;
    logic                       rd_en;
    logic                       is_read;
    logic                       run_last;
    logic [bls_pkg::CNT_W-1:0]  rd_pos;

    assign slot_free = !out_valid_reg || !out_stall;
    assign is_read   = cur_reg.kind == bls_pkg::KIND_READ;
    assign run_last  = (idx_reg + bls_pkg::CNT_W'(1)) == cur_reg.run_len;
    assign rd_pos    = cur_reg.addr + idx_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    idx_next = '0;
                    mem_we   = q_head.kind == bls_pkg::KIND_PUSH;
                    if (q_head.kind == bls_pkg::KIND_READ)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    if (is_read && !run_last)
                    begin
                        idx_next   = idx_reg + bls_pkg::CNT_W'(1);
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result slot occupancy
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // descriptor and result payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (load)
        begin
            data_byte_reg  <= is_read ? rd_data_reg : '0;
            data_valid_reg <= is_read;
            last_reg       <= !is_read || run_last;
            error_reg      <= cur_reg.err;
            occupancy_reg  <= cur_reg.occ;
            empty_res_reg  <= cur_reg.occ == '0;
        end
    end

    // stack memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_head.addr[ADDR_W-1:0]] <= q_head.wr_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_pos[ADDR_W-1:0]];
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_byte_reg;
    assign data_valid = data_valid_reg;
    assign last       = last_reg;
    assign error      = error_reg;
    assign occupancy  = occupancy_reg;
    assign empty_res  = empty_res_reg;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for byte_lifo_stack_top. A shadow stack predicts every
// result of each accepted command; a checker compares each result
// transaction, field by field, with the oldest prediction. The sender runs
// in bursts with gaps and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 64;
    // cycles with no transaction on either side before the run is abandoned
    localparam int IDLE_LIMIT  = 2000;
    // settle time after the last result
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [bls_pkg::BYTE_W-1:0] data_byte;
        logic                       data_valid;
        logic                       last;
        logic [bls_pkg::ERR_W-1:0]  error;
        logic [bls_pkg::CNT_W-1:0]  occupancy;
        logic                       empty_res;
    } stack_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [bls_pkg::CMD_W-1:0]  command;
    logic [bls_pkg::BYTE_W-1:0] push_byte;
    logic [bls_pkg::CNT_W-1:0]  count;
    logic                       out_valid;
    logic                       out_stall;
    logic [bls_pkg::BYTE_W-1:0] data_byte;
    logic                       data_valid;
    logic                       last;
    logic [bls_pkg::ERR_W-1:0]  error;
    logic [bls_pkg::CNT_W-1:0]  occupancy;
    logic                       empty_res;

    // shadow stack
    logic [bls_pkg::BYTE_W-1:0] shadow_mem [STACK_DEPTH];
    int unsigned                shadow_top;

    stack_result_t     expected_results[$];
    int                mismatch_count;

    // sender burst state
    int                burst_left;
    bit                sender_quiet;

    byte_lifo_stack_top #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .push_byte  (push_byte),
        .count      (count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .data_valid (data_valid),
        .last       (last),
        .error      (error),
        .occupancy  (occupancy),
        .empty_res  (empty_res)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // queue one predicted result, occupancy taken after the command
    function automatic void add_expected(input logic [bls_pkg::BYTE_W-1:0] b,
                                         input logic dv, input logic lst,
                                         input logic [bls_pkg::ERR_W-1:0] err);
        stack_result_t r;
        r.data_byte  = b;
        r.data_valid = dv;
        r.last       = lst;
        r.error      = err;
        r.occupancy  = bls_pkg::CNT_W'(shadow_top);
        r.empty_res  = (shadow_top == 0);
        expected_results.push_back(r);
    endfunction

    // apply one accepted command to the shadow stack
    function automatic void predict_stack_results(input logic [bls_pkg::CMD_W-1:0] cmd,
                                                  input logic [bls_pkg::BYTE_W-1:0] b,
                                                  input logic [bls_pkg::CNT_W-1:0] n);
        int unsigned base;
        logic [bls_pkg::BYTE_W-1:0] rd;
        case (cmd)
            bls_pkg::CMD_PUSH:
            begin
                if (shadow_top >= STACK_DEPTH)
                begin
                    add_expected('0, 1'b0, 1'b1, bls_pkg::ERR_FULL);
                end
                else
                begin
                    shadow_mem[shadow_top] = b;
                    shadow_top++;
                    add_expected('0, 1'b0, 1'b1, bls_pkg::ERR_OK);
                end
            end
            bls_pkg::CMD_POP, bls_pkg::CMD_PEEK:
            begin
                if (shadow_top == 0)
                begin
                    add_expected('0, 1'b0, 1'b1, bls_pkg::ERR_EMPTY);
                end
                else
                begin
                    rd = shadow_mem[shadow_top - 1];
                    if (cmd == bls_pkg::CMD_POP)
                        shadow_top--;
                    add_expected(rd, 1'b1, 1'b1, bls_pkg::ERR_OK);
                end
            end
            bls_pkg::CMD_PEEK_N, bls_pkg::CMD_POP_N:
            begin
                if (n > shadow_top)
                begin
                    add_expected('0, 1'b0, 1'b1, bls_pkg::ERR_COUNT);
                end
                else if (n == 0)
                begin
                    add_expected('0, 1'b0, 1'b1, bls_pkg::ERR_OK);
                end
                else
                begin
                    base = shadow_top - n;
                    if (cmd == bls_pkg::CMD_POP_N)
                        shadow_top = base;
                    // deepest selected byte first, top byte last
                    for (int unsigned i = 0; i < n; i++)
                        add_expected(shadow_mem[base + i], 1'b1, (i + 1 == n),
                                     bls_pkg::ERR_OK);
                end
            end
            // status query and the unused codes
            default:
            begin
                add_expected('0, 1'b0, 1'b1, bls_pkg::ERR_OK);
            end
        endcase
    endfunction

    // send one command transaction, with a random gap at burst boundaries
    task automatic send_command(input logic [bls_pkg::CMD_W-1:0] cmd,
                                input logic [bls_pkg::BYTE_W-1:0] b,
                                input logic [bls_pkg::CNT_W-1:0] n);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_quiet ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        command   <= cmd;
        push_byte <= b;
        count     <= n;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_stack_results(cmd, b, n);
    endtask

    // compare one result transaction with the oldest prediction
    function automatic void check_result();
        stack_result_t exp_r;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result byte=%0h dv=%0b last=%0b err=%0d occ=%0d empty=%0b",
                     $time, data_byte, data_valid, last, error, occupancy, empty_res);
            mismatch_count++;
            return;
        end
        exp_r = expected_results.pop_front();
        if (data_byte !== exp_r.data_byte)
        begin
            $display("%0t: data_byte expected %0h actual %0h", $time, exp_r.data_byte, data_byte);
            mismatch_count++;
        end
        if (data_valid !== exp_r.data_valid)
        begin
            $display("%0t: data_valid expected %0b actual %0b", $time, exp_r.data_valid,
                     data_valid);
            mismatch_count++;
        end
        if (last !== exp_r.last)
        begin
            $display("%0t: last expected %0b actual %0b", $time, exp_r.last, last);
            mismatch_count++;
        end
        if (error !== exp_r.error)
        begin
            $display("%0t: error expected %0d actual %0d", $time, exp_r.error, error);
            mismatch_count++;
        end
        if (occupancy !== exp_r.occupancy)
        begin
            $display("%0t: occupancy expected %0d actual %0d", $time, exp_r.occupancy,
                     occupancy);
            mismatch_count++;
        end
        if (empty_res !== exp_r.empty_res)
        begin
            $display("%0t: empty_res expected %0b actual %0b", $time, exp_r.empty_res,
                     empty_res);
            mismatch_count++;
        end
    endfunction

    // receiver: check accepted results, then pick the next stall value
    initial
    begin
        int mode;
        int seg_left;
        int phase;
        int hold;
        int period;
        mode      = 0;
        seg_left  = 0;
        phase     = 0;
        hold      = 1;
        period    = 2;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
            if (seg_left == 0)
            begin
                mode   = $urandom_range(0, 3);
                phase  = 0;
                hold   = $urandom_range(1, 4);
                period = hold + $urandom_range(1, 6);
                seg_left = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(10, 40);
            end
            seg_left--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                2:
                begin
                    out_stall <= (phase < hold);
                    phase = (phase + 1) % period;
                end
                default: out_stall <= 1'b1;
            endcase
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb failed");
        $finish;
    end

    // empty-stack cases, unused codes, small runs and count errors
    task automatic test_directed();
        send_command(bls_pkg::CMD_STATUS, 8'h00, 7'd0);
        send_command(bls_pkg::CMD_POP,    8'h00, 7'd0);
        send_command(bls_pkg::CMD_PEEK,   8'hFF, 7'd0);
        send_command(bls_pkg::CMD_PEEK_N, 8'h00, 7'd0);
        send_command(bls_pkg::CMD_POP_N,  8'h00, 7'd0);
        send_command(bls_pkg::CMD_PEEK_N, 8'h00, 7'd1);
        send_command(bls_pkg::CMD_POP_N,  8'h00, 7'h7F);
        send_command(3'd6,                8'h00, 7'd0);
        send_command(3'd7,                8'hFF, 7'h7F);
        send_command(bls_pkg::CMD_PUSH,   8'h00, 7'd0);
        send_command(bls_pkg::CMD_PUSH,   8'hFF, 7'h7F);
        send_command(bls_pkg::CMD_PUSH,   8'hA5, 7'd0);
        send_command(bls_pkg::CMD_PUSH,   8'h5A, 7'd0);
        send_command(bls_pkg::CMD_PEEK,   8'h00, 7'd0);
        send_command(bls_pkg::CMD_PEEK_N, 8'h00, 7'd4);
        send_command(bls_pkg::CMD_PEEK_N, 8'h00, 7'd5);
        send_command(bls_pkg::CMD_POP,    8'h00, 7'd0);
        send_command(bls_pkg::CMD_STATUS, 8'hFF, 7'h7F);
        send_command(bls_pkg::CMD_POP_N,  8'h00, 7'd2);
        send_command(bls_pkg::CMD_PEEK_N, 8'h00, 7'd0);
        send_command(bls_pkg::CMD_POP_N,  8'h00, 7'd1);
        send_command(bls_pkg::CMD_POP,    8'h00, 7'd0);
        send_command(bls_pkg::CMD_PEEK,   8'h00, 7'd0);
    endtask

    // fill to the top, overflow, full-depth runs, then empty again
    task automatic test_full_stack();
        while (shadow_top < STACK_DEPTH)
            send_command(bls_pkg::CMD_PUSH, bls_pkg::BYTE_W'($urandom),
                         bls_pkg::CNT_W'($urandom));
        send_command(bls_pkg::CMD_PUSH,   bls_pkg::BYTE_W'($urandom), 7'd0);
        send_command(bls_pkg::CMD_PUSH,   bls_pkg::BYTE_W'($urandom), 7'd0);
        send_command(bls_pkg::CMD_PEEK,   8'h00, 7'd0);
        send_command(bls_pkg::CMD_STATUS, 8'h00, 7'd0);
        send_command(bls_pkg::CMD_PEEK_N, 8'h00, bls_pkg::CNT_W'(STACK_DEPTH));
        send_command(bls_pkg::CMD_POP_N,  8'h00, bls_pkg::CNT_W'(STACK_DEPTH + 1));
        send_command(bls_pkg::CMD_POP,    8'h00, 7'd0);
        send_command(bls_pkg::CMD_PUSH,   bls_pkg::BYTE_W'($urandom), 7'd0);
        send_command(bls_pkg::CMD_POP_N,  8'h00, bls_pkg::CNT_W'(STACK_DEPTH));
        send_command(bls_pkg::CMD_POP,    8'h00, 7'd0);
    endtask

    // random mix, mostly commands that fit the occupancy, with some noise
    task automatic test_random_mix(input int items);
        int r;
        int small_max;
        logic [bls_pkg::CMD_W-1:0] cmd;
        logic [bls_pkg::CNT_W-1:0] n;
        for (int k = 0; k < items; k++)
        begin
            if (k % 20 == 0)
                sender_quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 40)
                cmd = bls_pkg::CMD_PUSH;
            else if (r < 52)
                cmd = bls_pkg::CMD_POP;
            else if (r < 62)
                cmd = bls_pkg::CMD_PEEK;
            else if (r < 74)
                cmd = bls_pkg::CMD_PEEK_N;
            else if (r < 86)
                cmd = bls_pkg::CMD_POP_N;
            else if (r < 94)
                cmd = bls_pkg::CMD_STATUS;
            else
                cmd = bls_pkg::CMD_W'($urandom_range(6, 7));
            n = bls_pkg::CNT_W'($urandom);
            if (cmd == bls_pkg::CMD_PEEK_N || cmd == bls_pkg::CMD_POP_N)
            begin
                small_max = (shadow_top < 8) ? shadow_top : 8;
                r = $urandom_range(0, 9);
                if (r == 0)
                    n = bls_pkg::CNT_W'($urandom_range(0, 127));
                else if (r < 3)
                    n = bls_pkg::CNT_W'(shadow_top);
                else
                    n = bls_pkg::CNT_W'($urandom_range(0, small_max));
            end
            send_command(cmd, bls_pkg::BYTE_W'($urandom), n);
        end
        sender_quiet = 1'b0;
    endtask

    // stimulus and final verdict
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        command        <= bls_pkg::CMD_STATUS;
        push_byte      <= '0;
        count          <= '0;
        shadow_top     = 0;
        mismatch_count = 0;
        burst_left     = 0;
        sender_quiet   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_stack();
        test_random_mix(75);

        // drain
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
